/* sv/vnf_pkg.sv */
// Shared constants, widths and the normalization table for the value-noise fBm block.
`default_nettype none
package vnf_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    // Clamped octave count, wide enough for sixteen octaves
    localparam int CNT_W     = 5;
    // One octave's rounded contribution and the running sum, Q2.30 plus headroom
    localparam int CONTRIB_W = 34;
    localparam int SUM_W     = 34;
    // Reciprocal of the total amplitude, unsigned Q.24
    localparam int RECIP_W   = 25;
    // Register stages inside one octave unit
    localparam int OCT_LAT   = 9;

    localparam logic [31:0] HASH_Y_MUL = 32'd57;
    localparam int          HASH_SHL   = 13;
    localparam logic [31:0] HASH_C1    = 32'd15731;
    localparam logic [31:0] HASH_C2    = 32'd789221;
    localparam logic [31:0] HASH_C3    = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7FFF_FFFF;
    localparam logic signed [31:0] CORNER_ONE = 32'sh4000_0000;

    localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] OUT_MIN = 16'sh8000;

    // 2^(n-1) / (2^n - 1), rounded to Q.24, indexed by octave count
    function automatic logic [RECIP_W-1:0] vnf_recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] q;
        case (n)
            5'd1:    q = 25'd16777216;
            5'd2:    q = 25'd11184811;
            5'd3:    q = 25'd9586981;
            5'd4:    q = 25'd8947849;
            5'd5:    q = 25'd8659208;
            5'd6:    q = 25'd8521761;
            5'd7:    q = 25'd8454660;
            5'd8:    q = 25'd8421505;
            5'd9:    q = 25'd8405024;
            5'd10:   q = 25'd8396808;
            5'd11:   q = 25'd8392706;
            5'd12:   q = 25'd8390657;
            5'd13:   q = 25'd8389632;
            5'd14:   q = 25'd8389120;
            5'd15:   q = 25'd8388864;
            5'd16:   q = 25'd8388736;
            default: q = 25'd16777216;
        endcase
        return q;
    endfunction

endpackage
`default_nettype wire

/* sv/value_noise_fbm.sv */
// Top level of the fractal value-noise (fBm) sampler.
//
// Each transfer on the s_ channel carries a point (signed fixed point with FRAC_BITS
// fraction bits) and an octave count; each m_ transfer carries one signed Q1.15 noise
// sample, in order. A count of zero acts as one and a count above MAX_OCTAVES acts as
// MAX_OCTAVES. All MAX_OCTAVES octave units run side by side, each a nine-stage pipeline
// (corner hash multiplies, smoothstep, two blend levels); unused octaves are masked off
// before a two-level adder tree, and a two-stage multiply, round and saturate finishes
// the sample. A new point is taken every cycle unless the output stalls. The whole
// pipeline advances together: it holds while the output register is full and m_ready
// is low, so s_ready follows m_ready in that case.
`default_nettype none
module value_noise_fbm #(
    parameter int MAX_OCTAVES = vnf_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = vnf_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic [3:0]         s_octave_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_noise_value
);
    import vnf_pkg::*;

    localparam int GROUPS = (MAX_OCTAVES + 3) / 4;
    // input stage, octave units, two adder levels, two normalization stages
    localparam int STAGES = 1 + OCT_LAT + 2 + 2;
    localparam int CNT_D  = OCT_LAT + 2;

    logic                      en;
    logic [STAGES-1:0]         vld_reg;
    logic [31:0]               x_reg;
    logic [31:0]               y_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [CNT_W-1:0]          cnt_reg [CNT_D];
    logic signed [CONTRIB_W-1:0] contrib [MAX_OCTAVES];
    logic signed [SUM_W-1:0]   grp_next [GROUPS];
    logic signed [SUM_W-1:0]   grp_reg  [GROUPS];
    logic signed [SUM_W-1:0]   total_next;
    logic signed [SUM_W-1:0]   total_reg;
    logic [RECIP_W-1:0]        recip_reg;

    // Advance everything unless a finished sample waits on the output
    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[STAGES-1];

    // Clamp the octave count into 1 .. MAX_OCTAVES
    always_comb begin
        if (s_octave_count == 4'd0) begin
            cnt_next = CNT_W'(1);
        end else if (CNT_W'(s_octave_count) > CNT_W'(MAX_OCTAVES)) begin
            cnt_next = CNT_W'(MAX_OCTAVES);
        end else begin
            cnt_next = CNT_W'(s_octave_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg      <= s_coord_x;
            y_reg      <= s_coord_y;
            cnt_reg[0] <= cnt_next;
            for (int k = 1; k < CNT_D; k++) begin
                cnt_reg[k] <= cnt_reg[k-1];
            end
        end
    end

    // One unit per octave; the frequency shift is folded into each unit
    generate
        for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
            vnf_octave #(
                .OCT_IDX  (k),
                .FRAC_BITS(FRAC_BITS)
            ) u_oct (
                .aclk   (aclk),
                .en     (en),
                .coord_x(x_reg),
                .coord_y(y_reg),
                .contrib(contrib[k])
            );
        end
    endgenerate

    // Adder tree: drop octaves at or beyond the count, sum groups of four, then groups
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if ((4*g + j) < MAX_OCTAVES) begin
                    if (CNT_W'(4*g + j) < cnt_reg[OCT_LAT]) begin
                        grp_next[g] = grp_next[g] + SUM_W'(contrib[4*g + j]);
                    end
                end
            end
        end
        total_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total_next = total_next + grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grp_reg   <= grp_next;
            total_reg <= total_next;
            recip_reg <= vnf_recip(cnt_reg[OCT_LAT+1]);
        end
    end

    vnf_norm u_norm (
        .aclk (aclk),
        .en   (en),
        .sum  (total_reg),
        .recip(recip_reg),
        .noise(m_noise_value)
    );

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A stalled output freezes every stage's valid bit
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // Clamped count entering the pipe stays in range
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> (cnt_reg[0] != '0 && cnt_reg[0] <= CNT_W'(MAX_OCTAVES)))
        else $error("octave count out of range");

    // Input is taken exactly when the pipeline advances
    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted item lost at entry");

endmodule
`default_nettype wire

/* sv/vnf_octave.sv */
// One octave of value noise: lattice split, corner hash, smoothstep and bilinear blend.
`default_nettype none
module vnf_octave #(
    parameter int OCT_IDX   = 0,
    parameter int FRAC_BITS = vnf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [31:0]                           coord_x,
    input  logic [31:0]                           coord_y,
    output logic signed [vnf_pkg::CONTRIB_W-1:0]  contrib
);
    import vnf_pkg::*;

    logic [31:0]        p_in   [2];
    logic [47:0]        p_wide [2];
    logic [31:0]        base   [2];
    logic [15:0]        t_next [2];
    logic [31:0]        na_next[4];
    logic [31:0]        nb_next[4];
    logic [51:0]        sm_poly[2];
    logic [31:0]        h_val  [4];
    logic signed [32:0] dif_a  [2];
    logic signed [50:0] rnd_a  [2];
    logic signed [33:0] dif_b;
    logic signed [51:0] rnd_b;
    logic signed [33:0] res;
    logic signed [33:0] res_rnd;

    // Stage A
    logic [31:0]        na_reg [4];
    logic [15:0]        ta_reg [2];
    // Stage B
    logic [31:0]        nb_reg [4];
    logic [31:0]        sq_reg [4];
    logic [15:0]        tb_reg [2];
    logic [31:0]        t2_reg [2];
    // Stage C
    logic [31:0]        nc_reg [4];
    logic [31:0]        pc_reg [4];
    logic [31:0]        t2c_reg[2];
    logic [47:0]        t3_reg [2];
    // Stage D
    logic [31:0]        m_reg  [4];
    logic [16:0]        sd_reg [2];
    // Stage E
    logic signed [31:0] v_reg  [4];
    logic [16:0]        se_reg [2];
    // Stage F
    logic signed [31:0] a_reg  [2];
    logic signed [50:0] pf_reg [2];
    logic [16:0]        syf_reg;
    // Stage G
    logic signed [32:0] lg_reg [2];
    logic [16:0]        syg_reg;
    // Stage H
    logic signed [32:0] toph_reg;
    logic signed [51:0] ph_reg;
    // Stage I
    logic signed [CONTRIB_W-1:0] contrib_reg;

    assign p_in[0] = coord_x << OCT_IDX;
    assign p_in[1] = coord_y << OCT_IDX;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            p_wide[j]  = {p_in[j], 16'b0};
            base[j]    = 32'($signed(p_in[j]) >>> FRAC_BITS);
            t_next[j]  = p_wide[j][FRAC_BITS+15 -: 16];
            sm_poly[j] = ((52'(t2c_reg[j]) * 52'd3) << 16) - (52'(t3_reg[j]) << 1)
                         + 52'h0_0000_8000_0000;
        end
        for (int c = 0; c < 4; c++) begin
            na_next[c] = (base[0] + (((c & 1) != 0) ? 32'd1 : 32'd0))
                       + (base[1] + (((c & 2) != 0) ? 32'd1 : 32'd0)) * HASH_Y_MUL;
            nb_next[c] = (na_reg[c] << HASH_SHL) ^ na_reg[c];
            h_val[c]   = (m_reg[c] + HASH_C3) & HASH_MASK;
        end
        for (int r = 0; r < 2; r++) begin
            dif_a[r] = 33'(v_reg[2*r+1]) - 33'(v_reg[2*r]);
            rnd_a[r] = (pf_reg[r] + 51'sd32768) >>> 16;
        end
        dif_b   = 34'(lg_reg[1]) - 34'(lg_reg[0]);
        rnd_b   = (ph_reg + 52'sd32768) >>> 16;
        res     = 34'(toph_reg) + 34'(rnd_b);
    end

    // Amplitude 2^-i with round-half-up
    generate
        if (OCT_IDX == 0) begin : g_amp0
            assign res_rnd = res;
        end else begin : g_ampn
            assign res_rnd = (res + (34'sd1 <<< (OCT_IDX - 1))) >>> OCT_IDX;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                na_reg[c] <= na_next[c];
                nb_reg[c] <= nb_next[c];
                sq_reg[c] <= nb_next[c] * nb_next[c];
                nc_reg[c] <= nb_reg[c];
                pc_reg[c] <= sq_reg[c] * HASH_C1 + HASH_C2;
                m_reg[c]  <= nc_reg[c] * pc_reg[c];
                v_reg[c]  <= CORNER_ONE - $signed(h_val[c]);
            end
            for (int j = 0; j < 2; j++) begin
                ta_reg[j]  <= t_next[j];
                tb_reg[j]  <= ta_reg[j];
                t2_reg[j]  <= 32'(ta_reg[j]) * 32'(ta_reg[j]);
                t2c_reg[j] <= t2_reg[j];
                t3_reg[j]  <= 48'(t2_reg[j]) * 48'(tb_reg[j]);
                sd_reg[j]  <= sm_poly[j][48:32];
                se_reg[j]  <= sd_reg[j];
            end
            for (int r = 0; r < 2; r++) begin
                a_reg[r]  <= v_reg[2*r];
                pf_reg[r] <= dif_a[r] * $signed({1'b0, se_reg[0]});
                lg_reg[r] <= 33'(a_reg[r]) + 33'(rnd_a[r]);
            end
            syf_reg     <= se_reg[1];
            syg_reg     <= syf_reg;
            toph_reg    <= lg_reg[0];
            ph_reg      <= dif_b * $signed({1'b0, syg_reg});
            contrib_reg <= res_rnd;
        end
    end

    assign contrib = contrib_reg;

endmodule
`default_nettype wire

/* sv/vnf_norm.sv */
// Normalization: multiply by the amplitude reciprocal, round and saturate to Q1.15.
`default_nettype none
module vnf_norm (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [vnf_pkg::SUM_W-1:0]     sum,
    input  logic [vnf_pkg::RECIP_W-1:0]          recip,
    output logic signed [15:0]                   noise
);
    import vnf_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;
    logic signed [15:0]       noise_next;
    logic signed [15:0]       noise_reg;

    always_comb begin
        rnd = (prod_reg + (PROD_W'(1) <<< 38)) >>> 39;
        if (rnd > PROD_W'(OUT_MAX)) begin
            noise_next = OUT_MAX;
        end else if (rnd < PROD_W'(OUT_MIN)) begin
            noise_next = OUT_MIN;
        end else begin
            noise_next = rnd[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= PROD_W'(sum) * $signed({1'b0, recip});
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the value-noise fBm sampler: directed and random points.
`default_nettype none

class noise_scoreboard;
    logic signed [15:0] pending_q[$];
    int                 err_count;

    function new();
        err_count = 0;
    endfunction

    static function longint rnd_shift(longint v, int s);
        longint b;
        if (s == 0) return v;
        b = v + (64'sd1 <<< (s - 1));
        return b >>> s;   // arithmetic shift is floor, same as the rounded division
    endfunction

    static function longint corner_val(logic [31:0] cx, logic [31:0] cy);
        logic [31:0] n;
        logic [31:0] h;
        n = cx + cy * 32'd57;
        n = (n << 13) ^ n;
        h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
        return (64'sd1 <<< 30) - longint'({32'd0, h});
    endfunction

    static function longint smooth(logic [31:0] p);
        logic [63:0] t;
        logic [63:0] v;
        t = {48'd0, p[15:0]};
        v = ((64'd3 * t * t) << 16) - 64'd2 * t * t * t + 64'h8000_0000;
        return longint'(v >> 32);
    endfunction

    static function longint mix(longint a, longint b, longint s);
        return a + rnd_shift((b - a) * s, 16);
    endfunction

    static function longint octave(logic [31:0] px, logic [31:0] py);
        logic [31:0] ix;
        logic [31:0] iy;
        longint sx, sy, top, bot;
        ix = {{16{px[31]}}, px[31:16]};
        iy = {{16{py[31]}}, py[31:16]};
        sx = smooth(px);
        sy = smooth(py);
        top = mix(corner_val(ix, iy), corner_val(ix + 1, iy), sx);
        bot = mix(corner_val(ix, iy + 1), corner_val(ix + 1, iy + 1), sx);
        return mix(top, bot, sy);
    endfunction

    static function logic signed [15:0] fbm_noise(logic [31:0] x, logic [31:0] y,
                                                  logic [3:0] cnt);
        int     n;
        longint total, d, q, r;
        n = (cnt < 1) ? 1 : ((cnt > 8) ? 8 : int'(cnt));
        total = 0;
        for (int i = 0; i < n; i++)
            total += rnd_shift(octave(x << i, y << i), i);
        d = (64'sd1 <<< n) - 1;
        q = ((64'sd1 <<< (n + 24)) + d) / (2 * d);
        r = rnd_shift(total * q, 39);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function void note_input(logic [31:0] x, logic [31:0] y, logic [3:0] cnt);
        pending_q.push_back(fbm_noise(x, y, cnt));
    endfunction

    function void check_result(logic signed [15:0] got);
        logic signed [15:0] want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected noise_value %0d", $time, got);
            err_count++;
            return;
        end
        want = pending_q.pop_front();
        if (want !== got) begin
            $display("%0t: noise_value mismatch expected %0d actual %0d", $time, want, got);
            err_count++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT = 14;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_y = '0;
    logic [3:0]         s_octave_count = 4'd1;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_noise_value;

    noise_scoreboard sb = new();
    bit stim_done = 0;
    bit hold_off_req = 0;   // sender asks receiver to stop for a long stretch

    value_noise_fbm u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_octave_count(s_octave_count),
        .m_valid(m_valid), .m_ready(m_ready), .m_noise_value(m_noise_value)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one point and hold it until the transfer happens.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [3:0] cnt);
        s_valid <= 1'b1;
        s_coord_x <= x;
        s_coord_y <= y;
        s_octave_count <= cnt;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(x, y, cnt);
    endtask

    // Drop valid for a number of idle cycles.
    task automatic idle_sender(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Random point: full range, near-lattice, near the origin, or near the wrap edges.
    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return $urandom();
        if (k < 7) return {16'($urandom_range(0, 65535)),
                           16'(($urandom() & 1) ? 16'hFFFF : 16'h0000)};
        if (k < 9) return $urandom_range(0, 2000) - 1000;
        return 32'h7FFF_0000 ^ $urandom_range(0, 65535) ^ (($urandom() & 1) ? 32'hFFFF_FFFF : 0);
    endfunction

    // Stimulus process
    initial begin
        logic [31:0] corners[8];
        corners = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme coordinates with every octave count, zero and oversize counts.
        for (int i = 0; i < 8; i++)
            send_point(corners[i], corners[7 - i], 4'(i + 1));
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0);
        send_point(32'h8000_0000, 32'h8000_0000, 4'd15);
        send_point(32'h0, 32'h0, 4'd9);
        send_point(32'hFFFF_FFFF, 32'h0, 4'd12);
        send_point(32'h4000_0000, 32'hC000_0000, 4'd8);   // wraps on shift
        send_point(32'h1234_5678, 32'hFEDC_BA98, 4'd8);
        for (int c = 0; c < 16; c++)
            send_point($urandom(), $urandom(), 4'(c));

        // Backpressure: receiver stops while the sender keeps offering.
        hold_off_req = 1;
        for (int i = 0; i < 40; i++)
            send_point(rand_coord(), rand_coord(), 4'($urandom_range(1, 8)));
        hold_off_req = 0;

        for (int i = 0; i < 1850; i++) begin
            logic [3:0] cnt;
            cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
            send_point(rand_coord(), rand_coord(), cnt);
            if (i == 900) begin
                // Drain: pause until every outstanding sample has come back.
                s_valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge aclk);
            end else if (i % 300 < 150) begin
                idle_sender(gap_len());
            end
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        bit held;
        held = 0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else if (($urandom_range(0, 3) == 0) && ($time / 20000) % 2 == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Monitor the result channel.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_noise_value);
    end

    // End of run
    initial begin
        wait (stim_done);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT * 3) @(posedge aclk);
        if (sb.err_count == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire
